>>> design/linear_probe_hash_table_top_defines.svh
// assertion macros for the linear probing hash table
// no dependencies; included by the top level
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// checked at every edge outside reset
`define LPHT_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LPHT_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/lpht_pkg.sv
// shared types and constants of the linear probing hash table
// no dependencies
package lpht_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_BITS_DEF = 32;
   localparam int HASH_BITS    = 32;
   localparam int LF_BITS      = 10;
   localparam int LF_SHIFT     = 10;
   localparam logic [LF_BITS-1:0] LF_RESET = 10'd768;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_ABSENT = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PR_EMPTY,
      PR_FOUND,
      PR_NONE
   } probe_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_P_RD,
      S_P_CHK,
      S_APPLY,
      S_R_RD,
      S_R_CHK,
      S_R_MOVE,
      S_R_CLR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] item_key;
      logic [31:0] hash_value;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [9:0]  slot_index;
      logic [1:0]  status;
      logic [10:0] entry_total;
   } rsp_type;

endpackage

>>> design/lpht_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> design/lpht_home.sv
// home slot unit: hash modulo capacity, a mask or a reciprocal multiply with one correction
// depends on lpht_pkg
module lpht_home
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [HASH_BITS-1:0]        hash_value,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] home
);

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int REM_BITS = IDX_BITS + 1;
   localparam bit POW2     = (CAPACITY & (CAPACITY - 1)) == 0;
   // floor(2^32 / capacity) leaves the quotient estimate at most one short
   localparam logic [HASH_BITS-1:0] RECIP = HASH_BITS'((64'd1 << HASH_BITS) / CAPACITY);
   localparam logic [REM_BITS-1:0]  CAP_R = REM_BITS'(CAPACITY);

   logic                   s1_ff, s1_in;
   logic                   s2_ff, s2_in;
   logic                   done_ff, done_in;
   logic [HASH_BITS-1:0]   hash_ff, hash_in;
   logic [HASH_BITS-1:0]   hash2_ff, hash2_in;
   logic [HASH_BITS-1:0]   quot_ff, quot_in;
   logic [2*HASH_BITS-1:0] prod;
   logic [REM_BITS-1:0]    raw;
   logic [IDX_BITS-1:0]    rem_ff, rem_in;

   always_comb begin
      prod     = (2*HASH_BITS)'(hash_ff) * (2*HASH_BITS)'(RECIP);
      // remainder is below twice the capacity, so only its low bits matter
      raw      = hash2_ff[REM_BITS-1:0] - REM_BITS'(quot_ff[REM_BITS-1:0] * CAP_R);
      s1_in    = start && !POW2;
      s2_in    = s1_ff;
      hash_in  = start ? hash_value : hash_ff;
      hash2_in = hash_ff;
      quot_in  = prod[2*HASH_BITS-1:HASH_BITS];
      done_in  = 1'b0;
      rem_in   = rem_ff;
      if (start && POW2) begin
         rem_in  = hash_value[IDX_BITS-1:0];
         done_in = 1'b1;
      end else if (s2_ff) begin
         if (raw >= CAP_R) begin
            rem_in = IDX_BITS'(raw - CAP_R);
         end else begin
            rem_in = raw[IDX_BITS-1:0];
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      hash2_ff <= hash2_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

>>> design/linear_probe_hash_table_top.sv
// steps: accept, home slot, then a read and a check per probed slot through the
// single ram read port, apply, output. remove then walks the cluster after the hole,
// probing each entry and moving it back to the hole its probe reaches.
// one transaction at a time; a new request is accepted only in the idle state.
// reset: synchronous; a clearing pass writes every slot empty, no accept.
module linear_probe_hash_table_top
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [LF_BITS-1:0] csr_wr_data
);

`include "linear_probe_hash_table_top_defines.svh"

   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int LIM_BITS  = CNT_BITS + LF_BITS;
   localparam int WORD_BITS = 1 + IDX_BITS + KEY_BITS;
   localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(CAPACITY - 1);

   state_type           state_ff, state_in;
   logic [LF_BITS-1:0]  lf_ff, lf_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   logic                rep_ff, rep_in;
   logic                rsp_valid_ff, rsp_valid_in;

   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDX_BITS-1:0] home_ff, home_in;
   logic [KEY_BITS-1:0] pkey_ff, pkey_in;
   logic [IDX_BITS-1:0] pslot_ff, pslot_in;
   logic [IDX_BITS-1:0] pcnt_ff, pcnt_in;
   probe_type           pres_ff, pres_in;
   logic [IDX_BITS-1:0] pwhere_ff, pwhere_in;
   logic [IDX_BITS-1:0] rk_ff, rk_in;
   logic [IDX_BITS-1:0] rcnt_ff, rcnt_in;
   logic [IDX_BITS-1:0] mhome_ff, mhome_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [IDX_BITS-1:0]  ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 rd_valid;
   logic [IDX_BITS-1:0]  rd_home;
   logic [KEY_BITS-1:0]  rd_key;

   logic                 home_start;
   logic                 home_done;
   logic [IDX_BITS-1:0]  home_out;
   logic [LIM_BITS-1:0]  limit;
   logic                 last_probe;

   lpht_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lpht_home #(
      .CAPACITY (CAPACITY)
   ) u_home (
      .clock      (clock),
      .reset      (reset),
      .start      (home_start),
      .hash_value (req_data.hash_value),
      .done       (home_done),
      .home       (home_out)
   );

   assign rd_valid   = ram_rd_data[WORD_BITS-1];
   assign rd_home    = ram_rd_data[KEY_BITS +: IDX_BITS];
   assign rd_key     = ram_rd_data[KEY_BITS-1:0];
   assign limit      = (LIM_BITS'(CAPACITY) * LIM_BITS'(lf_ff)) >> LF_SHIFT;
   assign last_probe = (pcnt_ff == LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == LAST) state_in = S_IDLE;
         S_IDLE:   if (req_valid) state_in = S_HOME;
         S_HOME:   if (home_done) state_in = S_P_RD;
         S_P_RD:   state_in = S_P_CHK;
         S_P_CHK: begin
            if (!rd_valid || rd_key == pkey_ff || last_probe) begin
               state_in = rep_ff ? S_R_MOVE : S_APPLY;
            end else begin
               state_in = S_P_RD;
            end
         end
         S_APPLY: begin
            if (op_ff == OP_REMOVE && pres_ff == PR_FOUND) state_in = S_R_RD;
            else state_in = S_RESP;
         end
         S_R_RD:   state_in = S_R_CHK;
         S_R_CHK:  state_in = rd_valid ? S_P_RD : S_RESP;
         S_R_MOVE: begin
            if (pres_ff == PR_EMPTY) state_in = S_R_CLR;
            else state_in = (rcnt_ff == LAST) ? S_RESP : S_R_RD;
         end
         S_R_CLR:  state_in = (rcnt_ff == LAST) ? S_RESP : S_R_RD;
         S_RESP:   if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      lf_in        = csr_wr_en ? csr_wr_data : lf_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      pkey_in      = pkey_ff;
      pslot_in     = pslot_ff;
      pcnt_in      = pcnt_ff;
      pres_in      = pres_ff;
      pwhere_in    = pwhere_ff;
      rk_in        = rk_ff;
      rcnt_in      = rcnt_ff;
      mhome_in     = mhome_ff;
      res_in       = res_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pwhere_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = pslot_ff;
      req_ready    = 1'b0;
      home_start   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = op_type'(req_data.op);
               key_in     = KEY_BITS'(req_data.item_key);
               home_start = 1'b1;
            end
         end
         S_HOME: begin
            if (home_done) begin
               home_in  = home_out;
               pslot_in = home_out;
               pkey_in  = key_ff;
               pcnt_in  = '0;
               rep_in   = 1'b0;
            end
         end
         S_P_CHK: begin
            if (!rd_valid) begin
               pres_in   = PR_EMPTY;
               pwhere_in = pslot_ff;
            end else if (rd_key == pkey_ff) begin
               pres_in   = PR_FOUND;
               pwhere_in = pslot_ff;
            end else if (last_probe) begin
               pres_in   = PR_NONE;
               pwhere_in = '0;
            end else begin
               pslot_in = (pslot_ff == LAST) ? '0 : pslot_ff + 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
            end
         end
         S_APPLY: begin
            res_in.hit        = (pres_ff == PR_FOUND);
            res_in.slot_index = 10'(pwhere_ff);
            res_in.status     = STAT_DONE;
            if (op_ff == OP_INSERT) begin
               if (pres_ff == PR_FOUND) begin
                  res_in.status = STAT_DONE;
               end else if (pres_ff == PR_EMPTY && LIM_BITS'(cnt_ff) < limit) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, home_ff, key_ff};
                  cnt_in      = cnt_ff + 1'b1;
               end else begin
                  res_in.status     = STAT_FULL;
                  res_in.slot_index = '0;
               end
            end else if (op_ff == OP_REMOVE && pres_ff == PR_FOUND) begin
               ram_wr_en = 1'b1;
               if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
               rk_in   = (pwhere_ff == LAST) ? '0 : pwhere_ff + 1'b1;
               rcnt_in = '0;
               rep_in  = 1'b1;
            end else if (pres_ff != PR_FOUND) begin
               res_in.status     = STAT_ABSENT;
               res_in.slot_index = '0;
            end
            res_in.entry_total = 11'(cnt_in);
         end
         S_R_RD: ram_rd_addr = rk_ff;
         S_R_CHK: begin
            if (rd_valid) begin
               pkey_in  = rd_key;
               mhome_in = rd_home;
               pslot_in = rd_home;
               pcnt_in  = '0;
            end
         end
         S_R_MOVE: begin
            if (pres_ff == PR_EMPTY) begin
               // entry moves back to the hole its probe now reaches
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b1, mhome_ff, pkey_ff};
            end else begin
               rk_in   = (rk_ff == LAST) ? '0 : rk_ff + 1'b1;
               rcnt_in = rcnt_ff + 1'b1;
            end
         end
         S_R_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rk_ff;
            rk_in       = (rk_ff == LAST) ? '0 : rk_ff + 1'b1;
            rcnt_in     = rcnt_ff + 1'b1;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lf_ff        <= LF_RESET;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lf_ff        <= lf_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      home_ff     <= home_in;
      pkey_ff     <= pkey_in;
      pslot_ff    <= pslot_in;
      pcnt_ff     <= pcnt_in;
      pres_ff     <= pres_in;
      pwhere_ff   <= pwhere_in;
      rk_ff       <= rk_in;
      rcnt_ff     <= rcnt_in;
      mhome_ff    <= mhome_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LPHT_CHECK(a_count_bound, clock, reset, CNT_BITS'(CAPACITY) >= cnt_ff, "entry count above capacity")
   `LPHT_CHECK(a_count_at_apply, clock, reset, cnt_ff != $past(cnt_ff) |-> $past(state_ff) == S_APPLY, "entry count changed outside apply")
   `LPHT_CHECK(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP, "result raised outside response state")
   `LPHT_CHECK_ALWAYS(a_no_accept_reset, clock, reset |=> !req_ready, "transaction accepted during clearing pass")

endmodule
